// File: src/nig_pkg.sv
// ----------------------------------------------------------------------------
// nig_pkg
// Shared widths, limits and register map of the NIG posterior update core.
// ----------------------------------------------------------------------------
package nig_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // input transfer fields
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 48;
    localparam int SUMSQ_W  = 62;
    localparam int CNT_LSB  = 0;
    localparam int SUM_LSB  = COUNT_W;
    localparam int SQ_LSB   = COUNT_W + SUM_W;
    localparam int S_TDATA_W = 128;

    // prior registers
    localparam int MEAN_W  = 32;
    localparam int VAR_W   = 32;
    localparam int SHAPE_W = 32;
    localparam int SCALE_W = 48;

    // result transfer fields
    localparam int POST_MEAN_W  = 32;
    localparam int POST_VAR_W   = 33;
    localparam int POST_SHAPE_W = 33;
    localparam int POST_SCALE_W = 62;
    localparam int M_TDATA_W    = 160;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam int MUL_CHUNK = 32;
    localparam int DIV_QBITS = 64;

    localparam logic [POST_VAR_W-1:0]   MAX33    = '1;
    localparam logic [POST_SCALE_W-1:0] MAX62    = '1;
    localparam logic [63:0]             MEAN_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0]             MEAN_NEG_MAG = 64'h0000_0000_8000_0000;

    localparam logic [MEAN_W-1:0]  PRIOR_MEAN_RST  = 32'd0;
    localparam logic [VAR_W-1:0]   PRIOR_VAR_RST   = 32'd65536;
    localparam logic [SHAPE_W-1:0] PRIOR_SHAPE_RST = 32'd131072;
    localparam logic [SCALE_W-1:0] PRIOR_SCALE_RST = 48'd131072;

    typedef enum logic [1:0] {
        REG_PRIOR_MEAN  = 2'd0,
        REG_PRIOR_VAR   = 2'd1,
        REG_PRIOR_SHAPE = 2'd2,
        REG_PRIOR_SCALE = 2'd3
    } reg_idx_t;

endpackage

// File: src/nig_mul.sv
// ----------------------------------------------------------------------------
// nig_mul
// Two-stage chunked multiplier: partial products, then their sum.
// ----------------------------------------------------------------------------
module nig_mul #(
    parameter int AW = 48,
    parameter int BW = 48,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [AW+BW-1:0] p,
    output logic [SW-1:0] side_out
);
    import nig_pkg::*;

    localparam int CW    = MUL_CHUNK;
    localparam int NA    = (AW + CW - 1) / CW;
    localparam int NB    = (BW + CW - 1) / CW;
    localparam int ACC_W = (NA + NB) * CW;

    logic [NA*CW-1:0] a_pad;
    logic [NB*CW-1:0] b_pad;
    logic [2*CW-1:0]  pp_reg [NA*NB];
    logic [SW-1:0]    side1_reg;
    logic             vld1_reg;
    logic [ACC_W-1:0] acc;
    logic [AW+BW-1:0] p_reg;
    logic [SW-1:0]    side2_reg;
    logic             vld2_reg;

    assign a_pad = (NA*CW)'(a);
    assign b_pad = (NB*CW)'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i*NB+j] <= a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
                end
            end
            side1_reg <= side_in;
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (ACC_W'(pp_reg[i*NB+j]) << ((i + j) * CW));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= (AW+BW)'(acc);
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_vld  = vld2_reg;
    assign p        = p_reg;
    assign side_out = side2_reg;

endmodule

// File: src/nig_div.sv
// ----------------------------------------------------------------------------
// nig_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit DIV_QBITS bits.
// ----------------------------------------------------------------------------
module nig_div #(
    parameter int NW = 96,
    parameter int DW = 33,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [nig_pkg::DIV_QBITS-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] side_out
);
    import nig_pkg::*;

    localparam int QW   = DIV_QBITS;
    localparam int HW   = NW - QW;
    localparam int CMPW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] div_reg  [QW];
    logic [QW-1:0] acc_reg  [QW+1];
    logic          ovf_reg  [QW+1];
    logic [SW-1:0] side_reg [QW+1];
    logic          vld_reg  [QW+1];

    // stage 0: split off the high part, flag a quotient that will not fit
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= DW'(dividend[NW-1:QW]);
            div_reg[0]  <= divisor;
            acc_reg[0]  <= dividend[QW-1:0];
            ovf_reg[0]  <= CMPW'(dividend[NW-1:QW]) >= CMPW'(divisor);
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] trial;
        logic        ge;

        assign trial = {rem_reg[k-1], acc_reg[k-1][QW-1]};
        assign ge    = trial >= {1'b0, div_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[k]  <= {acc_reg[k-1][QW-2:0], ge};
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end

        if (k < QW) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? DW'(trial - {1'b0, div_reg[k-1]}) : trial[DW-1:0];
                    div_reg[k] <= div_reg[k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign quo      = acc_reg[QW];
    assign ovf      = ovf_reg[QW];
    assign side_out = side_reg[QW];

endmodule

// File: src/nig_posterior_update_core.sv
// ----------------------------------------------------------------------------
// nig_posterior_update_core
// Normal-Inverse-Gamma conjugate posterior update, fixed point, pipelined.
//
//   port group   dir  fields (lsb first)
//   s_axis       in   count[15:0], sum[63:16], sum_squares[125:64]
//   m_axis       out  post_mean, post_kappa, post_shape, post_scale;
//                     tuser: empty_cluster
//   apb          in   prior_mean @0x00, prior_kappa @0x08, shape @0x10,
//                     scale @0x18
//
// One transfer per cycle while m_axis does not stall; the path runs through the 65-stage
// quotient pipelines (an entry stage, then one quotient bit per stage) plus multiplier stages.
// Reset is synchronous, active low; it clears the valid chain and loads the
// prior defaults.
// A stall on m_axis freezes the whole pipeline; nothing moves or drops.
// ----------------------------------------------------------------------------
module nig_posterior_update_core #(
    parameter int COUNT_BITS = nig_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = nig_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // count, sum, sum_squares, zero fill
    input  logic [nig_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // post_mean, post_kappa, post_shape, post_scale
    output logic [nig_pkg::M_TDATA_W-1:0]     m_tdata,
    // empty_cluster
    output logic [0:0]                        m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nig_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nig_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nig_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import nig_pkg::*;

    localparam int C       = COUNT_BITS;
    localparam int F       = FRAC_BITS;
    localparam int DEN_W   = ((32 > C + F) ? 32 : C + F) + 1;
    localparam int SH_W    = ((32 > C + F - 1) ? 32 : C + F - 1) + 1;
    localparam int NUM_W   = ((64 > SUM_W + F) ? 64 : SUM_W + F) + 1;
    localparam int NF_W    = C + F;
    localparam int ND_W    = C + DEN_W;
    localparam int NM_W    = C + 33;
    localparam int DS_W    = ((48 > C + 32) ? 48 : C + 32) + 2;
    localparam int DM_W    = DS_W - 1;
    localparam int SM_W    = SUM_W;
    localparam int SSQ_W   = 2 * SM_W;
    localparam int DSQ_W   = 2 * DM_W;
    localparam int X_W     = DSQ_W + VAR_W;
    localparam int Y_W     = X_W - F;
    localparam int SIDE1_W = NUM_W + NF_W + ND_W + DEN_W + SUMSQ_W + C;
    localparam int SIDE2_W = SSQ_W + 1 + SIDE1_W;
    localparam int SIDEM_W = C + DEN_W;
    localparam int ADDR_LSB = 3;

    // ---------------- configuration ----------------
    logic [MEAN_W-1:0]  prior_mean_reg;
    logic [VAR_W-1:0]   prior_var_reg;
    logic [SHAPE_W-1:0] prior_shape_reg;
    logic [SCALE_W-1:0] prior_scale_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:ADDR_LSB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_mean_reg  <= PRIOR_MEAN_RST;
            prior_var_reg   <= PRIOR_VAR_RST;
            prior_shape_reg <= PRIOR_SHAPE_RST;
            prior_scale_reg <= PRIOR_SCALE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PRIOR_MEAN:  prior_mean_reg  <= pwdata[MEAN_W-1:0];
                REG_PRIOR_VAR:   prior_var_reg   <= pwdata[VAR_W-1:0];
                REG_PRIOR_SHAPE: prior_shape_reg <= pwdata[SHAPE_W-1:0];
                REG_PRIOR_SCALE: prior_scale_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PRIOR_MEAN:  prdata = APB_DATA_W'(prior_mean_reg);
            REG_PRIOR_VAR:   prdata = APB_DATA_W'(prior_var_reg);
            REG_PRIOR_SHAPE: prdata = APB_DATA_W'(prior_shape_reg);
            REG_PRIOR_SCALE: prdata = APB_DATA_W'(prior_scale_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1: capture
    logic                     v1_reg;
    logic [C-1:0]             n1_reg;
    logic signed [SUM_W-1:0]  s1_reg;
    logic [SUMSQ_W-1:0]       sq1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg  <= C'(s_tdata[CNT_LSB +: COUNT_W]);
            s1_reg  <= s_tdata[SUM_LSB +: SUM_W];
            sq1_reg <= s_tdata[SQ_LSB +: SUMSQ_W];
        end
    end

    // stage 2: magnitudes, first products, denominator
    logic                     v2_reg;
    logic [C-1:0]             n2_reg;
    logic signed [SUM_W-1:0]  s2_reg;
    logic [SM_W-1:0]          smag2_reg;
    logic                     sneg2_reg;
    logic                     mneg2_reg;
    logic [63:0]              pa2_reg;
    logic signed [NM_W-1:0]   nm2_reg;
    logic [DEN_W-1:0]         den2_reg;
    logic [SUMSQ_W-1:0]       sq2_reg;
    logic [MEAN_W-1:0]        mmag;

    assign mmag = prior_mean_reg[MEAN_W-1] ? (MEAN_W'(0) - prior_mean_reg) : prior_mean_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_reg    <= n1_reg;
            s2_reg    <= s1_reg;
            sq2_reg   <= sq1_reg;
            smag2_reg <= s1_reg[SUM_W-1] ? SM_W'(-s1_reg) : SM_W'(s1_reg);
            sneg2_reg <= s1_reg[SUM_W-1];
            mneg2_reg <= prior_mean_reg[MEAN_W-1];
            pa2_reg   <= mmag * prior_var_reg;
            nm2_reg   <= $signed({1'b0, n1_reg}) * $signed(prior_mean_reg);
            den2_reg  <= DEN_W'(prior_var_reg) + (DEN_W'(n1_reg) << F);
        end
    end

    // stage 3: deviation, signed numerator, divisors
    logic                     v3_reg;
    logic [C-1:0]             n3_reg;
    logic signed [DS_W-1:0]   d3_reg;
    logic [NUM_W:0]           nsum3_reg;
    logic                     same3_reg;
    logic                     sneg3_reg;
    logic                     mneg3_reg;
    logic [ND_W-1:0]          nden3_reg;
    logic [NF_W-1:0]          nf3_reg;
    logic [DEN_W-1:0]         den3_reg;
    logic [SUMSQ_W-1:0]       sq3_reg;
    logic [SM_W-1:0]          smag3_reg;
    logic [NUM_W:0]           pb_ext;
    logic [NUM_W:0]           pa_ext;

    assign pb_ext = (NUM_W+1)'(smag2_reg) << F;
    assign pa_ext = (NUM_W+1)'(pa2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_reg    <= n2_reg;
            d3_reg    <= DS_W'(s2_reg) - DS_W'(nm2_reg);
            nsum3_reg <= (sneg2_reg == mneg2_reg) ? (pa_ext + pb_ext) : (pa_ext - pb_ext);
            same3_reg <= (sneg2_reg == mneg2_reg);
            sneg3_reg <= sneg2_reg;
            mneg3_reg <= mneg2_reg;
            nden3_reg <= ND_W'(n2_reg) * ND_W'(den2_reg);
            nf3_reg   <= NF_W'(n2_reg) << F;
            den3_reg  <= den2_reg;
            sq3_reg   <= sq2_reg;
            smag3_reg <= smag2_reg;
        end
    end

    // stage 4: absolute values
    logic                     v4_reg;
    logic [C-1:0]             n4_reg;
    logic [DM_W-1:0]          dmag4_reg;
    logic [NUM_W-1:0]         num4_reg;
    logic                     nneg4_reg;
    logic [ND_W-1:0]          nden4_reg;
    logic [NF_W-1:0]          nf4_reg;
    logic [DEN_W-1:0]         den4_reg;
    logic [SUMSQ_W-1:0]       sq4_reg;
    logic [SM_W-1:0]          smag4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n4_reg    <= n3_reg;
            dmag4_reg <= d3_reg[DS_W-1] ? DM_W'(-d3_reg) : DM_W'(d3_reg);
            num4_reg  <= nsum3_reg[NUM_W] ? NUM_W'(-nsum3_reg) : NUM_W'(nsum3_reg);
            nneg4_reg <= same3_reg ? sneg3_reg : (nsum3_reg[NUM_W] ? sneg3_reg : mneg3_reg);
            nden4_reg <= nden3_reg;
            nf4_reg   <= nf3_reg;
            den4_reg  <= den3_reg;
            sq4_reg   <= sq3_reg;
            smag4_reg <= smag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ---------------- squares ----------------
    logic               vm1a, vm1b;
    logic [SSQ_W-1:0]   ssq_m1;
    logic [DSQ_W-1:0]   dsq_m1;
    logic [SIDE1_W-1:0] side1_in, side1_out;
    logic [0:0]         nneg_m1;

    assign side1_in = {num4_reg, nf4_reg, nden4_reg, den4_reg, sq4_reg, n4_reg};

    nig_mul #(.AW(SM_W), .BW(SM_W), .SW(SIDE1_W)) u_mul_ssq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(v4_reg),
        .a(smag4_reg), .b(smag4_reg), .side_in(side1_in),
        .out_vld(vm1a), .p(ssq_m1), .side_out(side1_out)
    );

    nig_mul #(.AW(DM_W), .BW(DM_W), .SW(1)) u_mul_dsq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(v4_reg),
        .a(dmag4_reg), .b(dmag4_reg), .side_in(nneg4_reg),
        .out_vld(vm1b), .p(dsq_m1), .side_out(nneg_m1)
    );

    // ---------------- shrinkage product ----------------
    logic               vm2;
    logic [X_W-1:0]     x_m2;
    logic [SIDE2_W-1:0] side2_in, side2_out;
    logic [SSQ_W-1:0]   ssq_m2;
    logic               nneg_m2;
    logic [NUM_W-1:0]   num_m2;
    logic [NF_W-1:0]    nf_m2;
    logic [ND_W-1:0]    nden_m2;
    logic [DEN_W-1:0]   den_m2;
    logic [SUMSQ_W-1:0] sq_m2;
    logic [C-1:0]       n_m2;

    assign side2_in = {ssq_m1, nneg_m1, side1_out};

    nig_mul #(.AW(DSQ_W), .BW(VAR_W), .SW(SIDE2_W)) u_mul_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vm1a && vm1b),
        .a(dsq_m1), .b(prior_var_reg), .side_in(side2_in),
        .out_vld(vm2), .p(x_m2), .side_out(side2_out)
    );

    assign {ssq_m2, nneg_m2, num_m2, nf_m2, nden_m2, den_m2, sq_m2, n_m2} = side2_out;

    // ---------------- quotients ----------------
    logic                  vd_mean, vd_t1, vd_t2;
    logic [DIV_QBITS-1:0]  q_mean, q_t1, q_t2;
    logic                  ov_mean, ov_t1, ov_t2;
    logic [SIDEM_W-1:0]    sidem_out;
    logic [C-1:0]          n_d;
    logic [DEN_W-1:0]      den_d;
    logic [SUMSQ_W-1:0]    sq_d;
    logic [0:0]            nneg_d;

    nig_div #(.NW(NUM_W), .DW(DEN_W), .SW(SIDEM_W)) u_div_mean (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vm2),
        .dividend(num_m2), .divisor(den_m2), .side_in({n_m2, den_m2}),
        .out_vld(vd_mean), .quo(q_mean), .ovf(ov_mean), .side_out(sidem_out)
    );

    nig_div #(.NW(SSQ_W), .DW(NF_W), .SW(SUMSQ_W)) u_div_t1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vm2),
        .dividend(ssq_m2), .divisor(nf_m2), .side_in(sq_m2),
        .out_vld(vd_t1), .quo(q_t1), .ovf(ov_t1), .side_out(sq_d)
    );

    nig_div #(.NW(Y_W), .DW(ND_W), .SW(1)) u_div_t2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vm2),
        .dividend(x_m2[X_W-1:F]), .divisor(nden_m2), .side_in(nneg_m2),
        .out_vld(vd_t2), .quo(q_t2), .ovf(ov_t2), .side_out(nneg_d)
    );

    assign {n_d, den_d} = sidem_out;

    // ---------------- final stage 1: mean saturation, residual ----------------
    logic                     vf1_reg;
    logic [POST_MEAN_W-1:0]   mean_f1_reg;
    logic [SUMSQ_W-1:0]       ss_f1_reg;
    logic [DIV_QBITS-1:0]     q2_f1_reg;
    logic                     ov2_f1_reg;
    logic [C-1:0]             n_f1_reg;
    logic [DEN_W-1:0]         den_f1_reg;
    logic [POST_MEAN_W-1:0]   mag_neg, mag_pos;

    assign mag_neg = (ov_mean || q_mean > MEAN_NEG_MAG) ? MEAN_NEG_MAG[POST_MEAN_W-1:0]
                                                        : q_mean[POST_MEAN_W-1:0];
    assign mag_pos = (ov_mean || q_mean > MEAN_POS_MAX) ? MEAN_POS_MAX[POST_MEAN_W-1:0]
                                                        : q_mean[POST_MEAN_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            mean_f1_reg <= nneg_d[0] ? (POST_MEAN_W'(0) - mag_neg) : mag_pos;
            ss_f1_reg   <= (ov_t1 || q_t1 >= DIV_QBITS'(sq_d)) ? '0
                                                               : (sq_d - q_t1[SUMSQ_W-1:0]);
            q2_f1_reg   <= q_t2;
            ov2_f1_reg  <= ov_t2;
            n_f1_reg    <= n_d;
            den_f1_reg  <= den_d;
        end
    end

    // ---------------- final stage 2: half sum, var and shape ----------------
    logic                     vf2_reg;
    logic [DIV_QBITS-1:0]     half_f2_reg;
    logic                     ov2_f2_reg;
    logic [POST_MEAN_W-1:0]   mean_f2_reg;
    logic [POST_VAR_W-1:0]    var_f2_reg;
    logic [POST_SHAPE_W-1:0]  shape_f2_reg;
    logic                     empty_f2_reg;
    logic [DIV_QBITS:0]       sum_f1;
    logic [SH_W-1:0]          shsum;

    assign sum_f1 = (DIV_QBITS+1)'(ss_f1_reg) + (DIV_QBITS+1)'(q2_f1_reg);
    assign shsum  = SH_W'(prior_shape_reg) + (SH_W'(n_f1_reg) << (F - 1));

    always_ff @(posedge aclk) begin
        if (en) begin
            half_f2_reg  <= sum_f1[DIV_QBITS:1];
            ov2_f2_reg   <= ov2_f1_reg;
            mean_f2_reg  <= mean_f1_reg;
            var_f2_reg   <= (den_f1_reg > DEN_W'(MAX33)) ? MAX33 : POST_VAR_W'(den_f1_reg);
            shape_f2_reg <= (shsum > SH_W'(MAX33)) ? MAX33 : POST_SHAPE_W'(shsum);
            empty_f2_reg <= (n_f1_reg == '0);
        end
    end

    // ---------------- output register ----------------
    logic [POST_MEAN_W-1:0]   post_mean_reg;
    logic [POST_VAR_W-1:0]    post_var_reg;
    logic [POST_SHAPE_W-1:0]  post_shape_reg;
    logic [POST_SCALE_W-1:0]  post_scale_reg;
    logic                     empty_reg;
    logic [DIV_QBITS:0]       tot;

    assign tot = (DIV_QBITS+1)'(half_f2_reg) + (DIV_QBITS+1)'(prior_scale_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            empty_reg <= empty_f2_reg;
            if (empty_f2_reg) begin
                post_mean_reg  <= prior_mean_reg;
                post_var_reg   <= POST_VAR_W'(prior_var_reg);
                post_shape_reg <= POST_SHAPE_W'(prior_shape_reg);
                post_scale_reg <= POST_SCALE_W'(prior_scale_reg);
            end else begin
                post_mean_reg  <= mean_f2_reg;
                post_var_reg   <= var_f2_reg;
                post_shape_reg <= shape_f2_reg;
                post_scale_reg <= (ov2_f2_reg || tot > (DIV_QBITS+1)'(MAX62)) ? MAX62
                                                                 : tot[POST_SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf1_reg      <= 1'b0;
            vf2_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vf1_reg      <= vd_mean && vd_t1 && vd_t2;
            vf2_reg      <= vf1_reg;
            m_tvalid_reg <= vf2_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {post_scale_reg, post_shape_reg, post_var_reg, post_mean_reg};
    assign m_tuser  = empty_reg;

    // ---------------- assertions ----------------
    a_shape_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !empty_reg |-> post_shape_reg != '0)
        else $error("posterior shape zero for a nonempty cluster");

    a_var_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !empty_reg |-> post_var_reg >= (POST_VAR_W'(1) << F))
        else $error("posterior var scaling below one count");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("output valid after reset");

endmodule
